@@ hw/rtl/first_fit_heap_allocator_assert.svh @@
// assertion macros shared by the allocator checker
`ifndef FIRST_FIT_HEAP_ALLOCATOR_ASSERT_SVH
`define FIRST_FIT_HEAP_ALLOCATOR_ASSERT_SVH

// property checked only out of reset
`define FFHA_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// property checked on every edge, reset included
`define FFHA_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ hw/rtl/ffha_pkg.sv @@
// types and constants of the first-fit heap allocator
package ffha_pkg;

  localparam int IN_W   = 32;
  localparam int OUT_W  = 16;
  localparam int BYTES_W = 16;
  localparam int ADDR_W = 12;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  typedef enum logic [4:0] {
    S_IDLE,
    S_DISP,
    S_A_INIT,
    S_A_RD,
    S_A_EVAL,
    S_A_TAKE,
    S_A_SPLIT1,
    S_A_SPLIT2,
    S_F_CHK,
    S_F_PV,
    S_F_PVE,
    S_F_MERGE,
    S_F_PUSH1,
    S_F_PUSH2,
    S_F_QRD,
    S_F_QRD2,
    S_F_QE,
    S_DONE
  } state_t;

  typedef enum logic [4:0] {
    OP_NOP,
    OP_LOAD,
    OP_FAIL,
    OP_A_INIT,
    OP_A_RD,
    OP_A_NEXT,
    OP_A_TAKE,
    OP_A_SPLIT1,
    OP_A_SPLIT2,
    OP_F_RD,
    OP_F_PV,
    OP_F_MERGE,
    OP_F_PUSH1,
    OP_F_PUSH2,
    OP_F_QRD,
    OP_F_QRD2,
    OP_F_QMERGE,
    OP_F_END,
    OP_EMIT
  } dp_op_t;

  typedef struct packed {
    logic cmd_free;
    logic zero_req;
    logic bad_addr;
    logic n_none;
    logic steps_done;
    logic lt_need;
    logic lt_split;
    logic pv_free;
    logic q_free;
    logic out_full;
  } stat_t;

endpackage

@@ hw/rtl/first_fit_heap_allocator.sv @@
// first-fit heap allocator with coalescing, top level
//
//  channel | dir | handshake              | word
//  in_     | in  | in_tvalid / in_tready  | cmd, request_bytes, payload_address
//  out_    | out | out_tvalid / out_tready| result_address, success
//
// an allocate walks the free list one entry at a time, reading the link
// memories for each entry visited; a free whose address is rejected ends
// as early as a zero-byte allocate does.
// one word is in work at a time; the next word is taken once the result sits
// in the output register, and a result stalled there holds the sequencer in
// its last state. reset empties the heap at once: entry 0 carries a written
// flag per memory, so there is no clearing pass.
module first_fit_heap_allocator #(
  parameter int HEAP_GRANULES   = 4096,
  parameter int GRANULE_BYTES   = 16,
  parameter int HEADER_GRANULES = 2
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_tvalid,
  output logic                       in_tready,
  // [0] cmd, [16:1] request_bytes, [28:17] payload_address
  input  logic [ffha_pkg::IN_W-1:0]  in_tdata,
  output logic                       out_tvalid,
  input  logic                       out_tready,
  // [11:0] result_address, [12] success
  output logic [ffha_pkg::OUT_W-1:0] out_tdata
);

  ffha_pkg::dp_op_t op;
  ffha_pkg::stat_t  stat;

  ffha_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .op        (op)
  );

  ffha_dp #(
    .HEAP_GRANULES   (HEAP_GRANULES),
    .GRANULE_BYTES   (GRANULE_BYTES),
    .HEADER_GRANULES (HEADER_GRANULES)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .op         (op),
    .stat       (stat),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

@@ hw/rtl/ffha_ctrl.sv @@
// sequencer of the allocator: walks alloc and free through micro-operations
module ffha_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  ffha_pkg::stat_t  stat,
  output ffha_pkg::dp_op_t op
);

  ffha_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ffha_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ffha_pkg::S_IDLE: begin
        if (in_tvalid) state_nxt = ffha_pkg::S_DISP;
      end
      ffha_pkg::S_DISP: begin
        state_nxt = stat.cmd_free ? ffha_pkg::S_F_CHK : ffha_pkg::S_A_INIT;
      end
      ffha_pkg::S_A_INIT: begin
        state_nxt = stat.zero_req ? ffha_pkg::S_DONE : ffha_pkg::S_A_RD;
      end
      ffha_pkg::S_A_RD: begin
        state_nxt = (stat.n_none || stat.steps_done) ? ffha_pkg::S_DONE : ffha_pkg::S_A_EVAL;
      end
      ffha_pkg::S_A_EVAL: begin
        if (stat.lt_need) state_nxt = ffha_pkg::S_A_RD;
        else if (stat.lt_split) state_nxt = ffha_pkg::S_A_TAKE;
        else state_nxt = ffha_pkg::S_A_SPLIT1;
      end
      ffha_pkg::S_A_TAKE:   state_nxt = ffha_pkg::S_DONE;
      ffha_pkg::S_A_SPLIT1: state_nxt = ffha_pkg::S_A_SPLIT2;
      ffha_pkg::S_A_SPLIT2: state_nxt = ffha_pkg::S_DONE;
      ffha_pkg::S_F_CHK: begin
        state_nxt = stat.bad_addr ? ffha_pkg::S_DONE : ffha_pkg::S_F_PV;
      end
      ffha_pkg::S_F_PV: state_nxt = ffha_pkg::S_F_PVE;
      ffha_pkg::S_F_PVE: begin
        state_nxt = stat.pv_free ? ffha_pkg::S_F_MERGE : ffha_pkg::S_F_PUSH1;
      end
      ffha_pkg::S_F_MERGE: state_nxt = ffha_pkg::S_F_QRD;
      ffha_pkg::S_F_PUSH1: state_nxt = ffha_pkg::S_F_PUSH2;
      ffha_pkg::S_F_PUSH2: state_nxt = ffha_pkg::S_F_QRD;
      ffha_pkg::S_F_QRD:   state_nxt = ffha_pkg::S_F_QRD2;
      ffha_pkg::S_F_QRD2:  state_nxt = ffha_pkg::S_F_QE;
      ffha_pkg::S_F_QE:    state_nxt = ffha_pkg::S_DONE;
      ffha_pkg::S_DONE: begin
        if (!stat.out_full) state_nxt = ffha_pkg::S_IDLE;
      end
      default: state_nxt = ffha_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    op        = ffha_pkg::OP_NOP;
    in_tready = 1'b0;
    unique case (state_r)
      ffha_pkg::S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) op = ffha_pkg::OP_LOAD;
      end
      ffha_pkg::S_DISP: op = ffha_pkg::OP_NOP;
      ffha_pkg::S_A_INIT: begin
        op = stat.zero_req ? ffha_pkg::OP_FAIL : ffha_pkg::OP_A_INIT;
      end
      ffha_pkg::S_A_RD: begin
        op = (stat.n_none || stat.steps_done) ? ffha_pkg::OP_FAIL : ffha_pkg::OP_A_RD;
      end
      ffha_pkg::S_A_EVAL: begin
        op = stat.lt_need ? ffha_pkg::OP_A_NEXT : ffha_pkg::OP_NOP;
      end
      ffha_pkg::S_A_TAKE:   op = ffha_pkg::OP_A_TAKE;
      ffha_pkg::S_A_SPLIT1: op = ffha_pkg::OP_A_SPLIT1;
      ffha_pkg::S_A_SPLIT2: op = ffha_pkg::OP_A_SPLIT2;
      ffha_pkg::S_F_CHK: begin
        op = stat.bad_addr ? ffha_pkg::OP_FAIL : ffha_pkg::OP_F_RD;
      end
      ffha_pkg::S_F_PV:    op = ffha_pkg::OP_F_PV;
      ffha_pkg::S_F_PVE:   op = ffha_pkg::OP_NOP;
      ffha_pkg::S_F_MERGE: op = ffha_pkg::OP_F_MERGE;
      ffha_pkg::S_F_PUSH1: op = ffha_pkg::OP_F_PUSH1;
      ffha_pkg::S_F_PUSH2: op = ffha_pkg::OP_F_PUSH2;
      ffha_pkg::S_F_QRD:   op = ffha_pkg::OP_F_QRD;
      ffha_pkg::S_F_QRD2:  op = ffha_pkg::OP_F_QRD2;
      ffha_pkg::S_F_QE: begin
        op = stat.q_free ? ffha_pkg::OP_F_QMERGE : ffha_pkg::OP_F_END;
      end
      ffha_pkg::S_DONE: begin
        if (!stat.out_full) op = ffha_pkg::OP_EMIT;
      end
      default: op = ffha_pkg::OP_NOP;
    endcase
  end

endmodule

@@ hw/rtl/ffha_dp.sv @@
// datapath of the allocator: link memories, walk registers and result register
module ffha_dp #(
  parameter int HEAP_GRANULES   = 4096,
  parameter int GRANULE_BYTES   = 16,
  parameter int HEADER_GRANULES = 2
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  ffha_pkg::dp_op_t            op,
  output ffha_pkg::stat_t             stat,
  input  logic [ffha_pkg::IN_W-1:0]   in_tdata,
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [ffha_pkg::OUT_W-1:0]  out_tdata
);

  localparam int IW = $clog2(HEAP_GRANULES);
  localparam int LW = IW + 1;
  localparam int XW = $clog2(65536 + HEADER_GRANULES * GRANULE_BYTES + GRANULE_BYTES);
  localparam int SH = XW + $clog2(GRANULE_BYTES) + 1;
  localparam longint RECIP = ((64'd1 << SH) + GRANULE_BYTES - 1) / GRANULE_BYTES;
  localparam int PW = ((LW > ffha_pkg::ADDR_W) ? LW : ffha_pkg::ADDR_W) + 1;
  localparam int CW = ((XW > LW) ? XW : LW) + 1;
  localparam int PAD1 = (1 + HEADER_GRANULES * GRANULE_BYTES + GRANULE_BYTES - 1)
                        / GRANULE_BYTES;
  localparam logic [LW-1:0] NONE = LW'(HEAP_GRANULES);
  localparam logic [LW-1:0] HDR  = LW'(HEADER_GRANULES);

  // input word fields
  logic                        cmd_r;
  logic [ffha_pkg::BYTES_W-1:0] bytes_r;
  logic [ffha_pkg::ADDR_W-1:0] p_r;

  logic [LW-1:0] n_r, steps_r, q_r, head_r, head_nxt;
  logic [XW-1:0] need_r;
  logic [ffha_pkg::ADDR_W-1:0] res_addr_r;
  logic res_ok_r;
  logic out_valid_r, out_valid_nxt;
  logic [ffha_pkg::OUT_W-1:0] out_data_r;

  // memory ports: pn phys_next, pp phys_prev, fn free_next, fp free_prev, iu in_use
  logic [LW-1:0] pn_mem [HEAP_GRANULES];
  logic [LW-1:0] pp_mem [HEAP_GRANULES];
  logic [LW-1:0] fn_mem [HEAP_GRANULES];
  logic [LW-1:0] fp_mem [HEAP_GRANULES];
  logic          iu_mem [HEAP_GRANULES];

  logic pn_re, pp_re, fn_re, fp_re, iu_re;
  logic pn_we, pp_we, fn_we, fp_we, iu_we;
  logic [LW-1:0] pn_ra, pp_ra, fn_ra, fp_ra, iu_ra;
  logic [LW-1:0] pn_wa, pp_wa, fn_wa, fp_wa, iu_wa;
  logic [LW-1:0] pn_wd, pp_wd, fn_wd, fp_wd;
  logic          iu_wd;
  logic [LW-1:0] pn_q, pp_q, fn_q, fp_q;
  logic          iu_q;
  logic pn_fix_r, pp_fix_r, fn_fix_r, fp_fix_r, iu_oob_r, iu_z_r;
  logic pn_e0_r, pp_e0_r, fn_e0_r, fp_e0_r, iu_e0_r;
  logic [LW-1:0] pn_v, pp_v, fn_v, fp_v;
  logic          iu_v;

  logic [XW-1:0]    x;
  logic [XW+SH-1:0] prod;
  logic [LW-1:0]    sz, m;
  logic [PW-1:0]    p_ext, nf_w;
  logic [LW-1:0]    nf;

  // entry 0 holds its reset value until first written; outside the heap links read none
  assign pn_v = pn_fix_r ? NONE : pn_q;
  assign pp_v = pp_fix_r ? NONE : pp_q;
  assign fn_v = fn_fix_r ? NONE : fn_q;
  assign fp_v = fp_fix_r ? NONE : fp_q;
  assign iu_v = iu_oob_r ? 1'b1 : (iu_z_r ? 1'b0 : iu_q);

  // padded size in granules via reciprocal multiply
  assign x    = XW'(bytes_r) + XW'(HEADER_GRANULES * GRANULE_BYTES + GRANULE_BYTES - 1);
  assign prod = (XW+SH)'(x) * (XW+SH)'(RECIP);

  assign sz = (pn_v > n_r) ? (pn_v - n_r) : '0;
  assign m  = LW'(CW'(n_r) + CW'(need_r));

  assign p_ext = PW'(p_r);
  assign nf_w  = p_ext - PW'(HEADER_GRANULES);
  assign nf    = nf_w[LW-1:0];

  always_comb begin
    stat            = '0;
    stat.cmd_free   = (cmd_r == ffha_pkg::CMD_FREE);
    stat.zero_req   = (bytes_r == '0);
    stat.bad_addr   = (p_ext < PW'(HEADER_GRANULES)) || (nf_w >= PW'(HEAP_GRANULES));
    stat.n_none     = (n_r >= NONE);
    stat.steps_done = (steps_r == NONE);
    stat.lt_need    = CW'(sz) < CW'(need_r);
    stat.lt_split   = CW'(sz) < (CW'(need_r) + CW'(PAD1));
    stat.pv_free    = (pp_v != NONE) && !iu_v;
    stat.q_free     = (q_r != NONE) && !iu_v;
    stat.out_full   = out_valid_r && !out_tready;
  end

  // memory commands per micro-operation
  always_comb begin
    pn_re = 1'b0; pp_re = 1'b0; fn_re = 1'b0; fp_re = 1'b0; iu_re = 1'b0;
    pn_ra = '0;   pp_ra = '0;   fn_ra = '0;   fp_ra = '0;   iu_ra = '0;
    pn_we = 1'b0; pp_we = 1'b0; fn_we = 1'b0; fp_we = 1'b0; iu_we = 1'b0;
    pn_wa = '0;   pp_wa = '0;   fn_wa = '0;   fp_wa = '0;   iu_wa = '0;
    pn_wd = '0;   pp_wd = '0;   fn_wd = '0;   fp_wd = '0;   iu_wd = 1'b0;
    head_nxt = head_r;
    case (op)
      ffha_pkg::OP_A_RD: begin
        pn_re = 1'b1; pn_ra = n_r;
        fn_re = 1'b1; fn_ra = n_r;
        fp_re = 1'b1; fp_ra = n_r;
      end
      ffha_pkg::OP_A_TAKE: begin
        if (fp_v >= NONE) head_nxt = fn_v;
        else begin
          fn_we = 1'b1; fn_wa = fp_v; fn_wd = fn_v;
        end
        fp_we = (fn_v != NONE); fp_wa = fn_v; fp_wd = fp_v;
        iu_we = 1'b1; iu_wa = n_r; iu_wd = 1'b1;
      end
      ffha_pkg::OP_A_SPLIT1: begin
        fn_we = 1'b1; fn_wa = m; fn_wd = fn_v;
        fp_we = 1'b1; fp_wa = m; fp_wd = fp_v;
        iu_we = 1'b1; iu_wa = m; iu_wd = 1'b0;
        pp_we = 1'b1; pp_wa = m; pp_wd = n_r;
        pn_we = 1'b1; pn_wa = m; pn_wd = pn_v;
      end
      ffha_pkg::OP_A_SPLIT2: begin
        if (fp_v >= NONE) head_nxt = m;
        else begin
          fn_we = 1'b1; fn_wa = fp_v; fn_wd = m;
        end
        fp_we = (fn_v != NONE); fp_wa = fn_v; fp_wd = m;
        iu_we = 1'b1; iu_wa = n_r; iu_wd = 1'b1;
        pp_we = (pn_v != NONE); pp_wa = pn_v; pp_wd = m;
        pn_we = 1'b1; pn_wa = n_r; pn_wd = m;
      end
      ffha_pkg::OP_F_RD: begin
        pp_re = 1'b1; pp_ra = nf;
        pn_re = 1'b1; pn_ra = nf;
      end
      ffha_pkg::OP_F_PV: begin
        iu_re = 1'b1; iu_ra = pp_v;
      end
      ffha_pkg::OP_F_MERGE: begin
        pn_we = 1'b1; pn_wa = pp_v; pn_wd = pn_v;
        pp_we = (pn_v != NONE); pp_wa = pn_v; pp_wd = pp_v;
      end
      ffha_pkg::OP_F_PUSH1: begin
        fn_we = 1'b1; fn_wa = n_r; fn_wd = head_r;
        fp_we = (head_r != NONE); fp_wa = head_r; fp_wd = n_r;
        iu_we = 1'b1; iu_wa = n_r; iu_wd = 1'b0;
      end
      ffha_pkg::OP_F_PUSH2: begin
        fp_we = 1'b1; fp_wa = n_r; fp_wd = NONE;
        head_nxt = n_r;
      end
      ffha_pkg::OP_F_QRD: begin
        pn_re = 1'b1; pn_ra = n_r;
      end
      ffha_pkg::OP_F_QRD2: begin
        iu_re = 1'b1; iu_ra = pn_v;
        fp_re = 1'b1; fp_ra = pn_v;
        fn_re = 1'b1; fn_ra = pn_v;
        pn_re = 1'b1; pn_ra = pn_v;
      end
      ffha_pkg::OP_F_QMERGE: begin
        if (fp_v >= NONE) head_nxt = fn_v;
        else begin
          fn_we = 1'b1; fn_wa = fp_v; fn_wd = fn_v;
        end
        fp_we = (fn_v != NONE); fp_wa = fn_v; fp_wd = fp_v;
        pn_we = 1'b1; pn_wa = n_r; pn_wd = pn_v;
        pp_we = (pn_v != NONE); pp_wa = pn_v; pp_wd = n_r;
      end
      default: begin
        head_nxt = head_r;
      end
    endcase
  end

  // link memories with registered read
  always_ff @(posedge clk) begin
    if (pn_we && (pn_wa < NONE)) pn_mem[pn_wa[IW-1:0]] <= pn_wd;
    if (pn_re) begin
      pn_q     <= pn_mem[pn_ra[IW-1:0]];
      pn_fix_r <= (pn_ra >= NONE) || ((pn_ra == '0) && !pn_e0_r);
    end
  end

  always_ff @(posedge clk) begin
    if (pp_we && (pp_wa < NONE)) pp_mem[pp_wa[IW-1:0]] <= pp_wd;
    if (pp_re) begin
      pp_q     <= pp_mem[pp_ra[IW-1:0]];
      pp_fix_r <= (pp_ra >= NONE) || ((pp_ra == '0) && !pp_e0_r);
    end
  end

  always_ff @(posedge clk) begin
    if (fn_we && (fn_wa < NONE)) fn_mem[fn_wa[IW-1:0]] <= fn_wd;
    if (fn_re) begin
      fn_q     <= fn_mem[fn_ra[IW-1:0]];
      fn_fix_r <= (fn_ra >= NONE) || ((fn_ra == '0) && !fn_e0_r);
    end
  end

  always_ff @(posedge clk) begin
    if (fp_we && (fp_wa < NONE)) fp_mem[fp_wa[IW-1:0]] <= fp_wd;
    if (fp_re) begin
      fp_q     <= fp_mem[fp_ra[IW-1:0]];
      fp_fix_r <= (fp_ra >= NONE) || ((fp_ra == '0) && !fp_e0_r);
    end
  end

  always_ff @(posedge clk) begin
    if (iu_we && (iu_wa < NONE)) iu_mem[iu_wa[IW-1:0]] <= iu_wd;
    if (iu_re) begin
      iu_q     <= iu_mem[iu_ra[IW-1:0]];
      iu_oob_r <= (iu_ra >= NONE);
      iu_z_r   <= (iu_ra == '0) && !iu_e0_r;
    end
  end

  // entry 0 written flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pn_e0_r <= 1'b0;
      pp_e0_r <= 1'b0;
      fn_e0_r <= 1'b0;
      fp_e0_r <= 1'b0;
      iu_e0_r <= 1'b0;
    end else begin
      if (pn_we && (pn_wa == '0)) pn_e0_r <= 1'b1;
      if (pp_we && (pp_wa == '0)) pp_e0_r <= 1'b1;
      if (fn_we && (fn_wa == '0)) fn_e0_r <= 1'b1;
      if (fp_we && (fp_wa == '0)) fp_e0_r <= 1'b1;
      if (iu_we && (iu_wa == '0)) iu_e0_r <= 1'b1;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (op == ffha_pkg::OP_EMIT) out_valid_nxt = 1'b1;
    else if (out_tready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      head_r      <= head_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // walk and result registers
  always_ff @(posedge clk) begin
    case (op)
      ffha_pkg::OP_LOAD: begin
        cmd_r   <= in_tdata[0];
        bytes_r <= in_tdata[ffha_pkg::BYTES_W:1];
        p_r     <= in_tdata[ffha_pkg::BYTES_W+ffha_pkg::ADDR_W:ffha_pkg::BYTES_W+1];
      end
      ffha_pkg::OP_FAIL: begin
        res_addr_r <= '0;
        res_ok_r   <= 1'b0;
      end
      ffha_pkg::OP_A_INIT: begin
        need_r  <= prod[XW+SH-1:SH];
        n_r     <= head_r;
        steps_r <= '0;
      end
      ffha_pkg::OP_A_NEXT: begin
        n_r     <= fn_v;
        steps_r <= steps_r + 1'b1;
      end
      ffha_pkg::OP_A_TAKE, ffha_pkg::OP_A_SPLIT2: begin
        res_addr_r <= ffha_pkg::ADDR_W'(n_r + HDR);
        res_ok_r   <= (ffha_pkg::ADDR_W'(n_r + HDR) != '0);
      end
      ffha_pkg::OP_F_RD:    n_r <= nf;
      ffha_pkg::OP_F_MERGE: n_r <= pp_v;
      ffha_pkg::OP_F_QRD2:  q_r <= pn_v;
      ffha_pkg::OP_F_QMERGE, ffha_pkg::OP_F_END: begin
        res_addr_r <= '0;
        res_ok_r   <= 1'b1;
      end
      ffha_pkg::OP_EMIT: begin
        out_data_r <= ffha_pkg::OUT_W'({res_ok_r, res_addr_r});
      end
      default: begin
        n_r <= n_r;
      end
    endcase
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

@@ hw/rtl/ffha_checker.sv @@
// port checker for the allocator, bound to the top level
`include "first_fit_heap_allocator_assert.svh"

module ffha_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_tvalid,
  input logic                       in_tready,
  input logic                       out_tvalid,
  input logic                       out_tready,
  input logic [ffha_pkg::OUT_W-1:0] out_tdata
);

  `FFHA_ASSERT(a_out_hold, clk, rst_n, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata), "result word dropped or changed while stalled")
  `FFHA_ASSERT_ALWAYS(a_rst_empty, clk, !rst_n |=> !out_tvalid, "result word present after reset")
  `FFHA_ASSERT(a_one_at_a_time, clk, rst_n, in_tvalid && in_tready |=> !in_tready, "second word taken while one is in work")
  `FFHA_ASSERT(a_fail_addr_zero, clk, rst_n, out_tvalid && !out_tdata[12] |-> out_tdata[11:0] == 12'd0, "failed result carries an address")

endmodule

bind first_fit_heap_allocator ffha_checker u_chk (.*);
